// ===== sv/bda_pkg.sv =====
// Shared constants and weight table for the binary to decimal ASCII converter.
package bda_pkg;

  localparam int Decades = 5;
  localparam int StepsPerDecade = 4;
  localparam int WeightCount = Decades * StepsPerDecade;

  localparam int MagWidth = 16;
  localparam int WeightWidth = 17;
  localparam int DecadeWidth = $clog2(Decades);
  localparam int StepWidth = $clog2(StepsPerDecade);
  localparam int WeightIndexWidth = $clog2(WeightCount);

  localparam logic [7:0] AsciiZero = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'h2D;
  localparam logic [7:0] AsciiNul = 8'h00;

  localparam logic [DecadeWidth-1:0] LastDecade = DecadeWidth'(Decades - 1);
  localparam logic [StepWidth-1:0] LastStep = StepWidth'(StepsPerDecade - 1);

  // Each decade weight scaled by 8, 4, 2 and 1, tried in that order.
  localparam logic [WeightWidth-1:0] Weights [WeightCount] = '{
    17'd80000, 17'd40000, 17'd20000, 17'd10000,
    17'd8000,  17'd4000,  17'd2000,  17'd1000,
    17'd800,   17'd400,   17'd200,   17'd100,
    17'd80,    17'd40,    17'd20,    17'd10,
    17'd8,     17'd4,     17'd2,     17'd1
  };

  typedef struct packed {
    logic                take;
    logic [MagWidth-1:0] remainder;
  } step_result_t;

endpackage

// ===== sv/bda_step_unit.sv =====
// Shared compare-subtract unit: one binary digit of a decimal digit per use.
module bda_step_unit
  import bda_pkg::*;
(
  input  logic [MagWidth-1:0]         remainder,
  input  logic [DecadeWidth-1:0]      decade,
  input  logic [StepWidth-1:0]        step,
  output step_result_t                result
);

  logic [WeightIndexWidth-1:0] index;
  logic [WeightWidth-1:0]      weight;
  logic [WeightWidth-1:0]      wide_rem;
  logic [WeightWidth-1:0]      diff;

  assign index = WeightIndexWidth'({decade, step});
  assign weight = Weights[index];
  assign wide_rem = {1'b0, remainder};
  assign diff = wide_rem - weight;

  always_comb begin
    result.take = (wide_rem >= weight);
    result.remainder = result.take ? diff[MagWidth-1:0] : remainder;
  end

endmodule

// ===== sv/binary_to_decimal_ascii_unit.sv =====
// Top level: sequencer that turns a 16-bit value into decimal ASCII characters.
// An item is taken when start is high and busy is low. For a negative signed value the '-' is
// produced in the cycle after the item is taken. Each decimal digit is then found by four
// compare-subtract steps of one shared unit against 8, 4, 2 and 1 times the decade weight, and
// a digit leaves in the cycle after its fourth step unless it is a leading zero of an earlier decade;
// the NUL follows in the cycle after the last digit.
// Characters appear on character/last for a single cycle each with strobe high; the receiver
// cannot stall them, and the block holds no more than the one output register.
module binary_to_decimal_ascii_unit
  import bda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [15:0] value,
  output logic        strobe,
  output logic [7:0]  character,
  output logic        last
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDigit = 2'd1;
  localparam logic [1:0] StNul = 2'd2;

  logic [1:0]             state;
  logic [MagWidth-1:0]    mag;
  logic [DecadeWidth-1:0] decade;
  logic [StepWidth-1:0]   step;
  logic [3:0]             digit;
  logic                   started;

  step_result_t           unit_out;
  logic [3:0]             digit_full;
  logic                   negative;
  logic                   emit_digit;

  bda_step_unit u_step (
    .remainder (mag),
    .decade    (decade),
    .step      (step),
    .result    (unit_out)
  );

  assign busy = (state != StIdle);
  assign negative = operation & value[15];
  assign digit_full = (step == '0) ? {3'b000, unit_out.take} : {digit[2:0], unit_out.take};
  assign emit_digit = (step == LastStep) &&
                      ((digit_full != 4'd0) || started || (decade == LastDecade));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      strobe <= 1'b0;
      started <= 1'b0;
      decade <= '0;
      step <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        StIdle: begin
          if (start) begin
            mag <= negative ? (~value + 16'd1) : value;
            decade <= '0;
            step <= '0;
            started <= 1'b0;
            state <= StDigit;
            if (negative) begin
              strobe <= 1'b1;
              character <= AsciiMinus;
              last <= 1'b0;
            end
          end
        end
        StDigit: begin
          mag <= unit_out.remainder;
          digit <= digit_full;
          step <= step + StepWidth'(1);
          if (emit_digit) begin
            started <= 1'b1;
            strobe <= 1'b1;
            character <= AsciiZero + {4'd0, digit_full};
            last <= 1'b0;
          end
          if (step == LastStep) begin
            if (decade == LastDecade) begin
              state <= StNul;
            end else begin
              decade <= decade + DecadeWidth'(1);
            end
          end
        end
        StNul: begin
          strobe <= 1'b1;
          character <= AsciiNul;
          last <= 1'b1;
          state <= StIdle;
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

endmodule

// ===== verif/binary_to_decimal_ascii_unit_tb.sv =====
// Self-checking testbench for the binary to decimal ASCII converter.
module binary_to_decimal_ascii_unit_tb
  import bda_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OpUnsigned = 1'b0;
  localparam logic OpSigned = 1'b1;
  localparam int DirectedCount = 21;
  localparam int RandomCount = 190;
  localparam int CalmTail = 40;
  localparam int DrainCycles = 30;
  localparam int CycleLimit = 100000;

  typedef struct {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  // Holds the characters still owed by the block and checks each one as it leaves.
  class text_scoreboard;
    text_char_t expected_text[$];
    int errors = 0;

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void push_char(logic [7:0] ch, logic lst);
      text_char_t entry;
      entry.character = ch;
      entry.last = lst;
      expected_text.push_back(entry);
    endfunction

    // Works out the decimal text for one accepted item.
    function void note_value(logic op, logic [15:0] val);
      logic [16:0] mag;
      int unsigned weight;
      int unsigned digit;
      bit begun;
      mag = {1'b0, val};
      begun = 0;
      if (op == OpSigned && val[15]) begin
        push_char(AsciiMinus, 1'b0);
        mag = 17'h10000 - {1'b0, val};
      end
      weight = 10000;
      for (int d = 0; d < 5; d++) begin
        digit = mag / weight;
        mag = mag - 17'(digit * weight);
        if (digit != 0 || begun || d == 4) begin
          begun = 1;
          push_char(AsciiZero + 8'(digit), 1'b0);
        end
        weight = weight / 10;
      end
      push_char(AsciiNul, 1'b1);
    endfunction

    task check_char(logic [7:0] ch, logic lst);
      text_char_t want;
      if (expected_text.size() == 0) begin
        report($sformatf("unexpected character %h last %b", ch, lst));
      end else begin
        want = expected_text.pop_front();
        if (ch !== want.character)
          report($sformatf("character %h, expected %h", ch, want.character));
        if (lst !== want.last)
          report($sformatf("last %b, expected %b", lst, want.last));
      end
    endtask

    function int pending();
      return expected_text.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        operation;
  logic [15:0] value;
  logic        strobe;
  logic [7:0]  character;
  logic        last;

  text_scoreboard sb = new();
  int cycles = 0;

  binary_to_decimal_ascii_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .value(value),
    .strobe(strobe),
    .character(character),
    .last(last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("binary_to_decimal_ascii_unit verification failed");
      $finish;
    end
  end

  // Values here are those from just before the edge, as the block saw them.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_value(operation, value);
      if (strobe) sb.check_char(character, last);
    end
  end

  task send_item(logic op, logic [15:0] val);
    @(negedge clk);
    start <= 1'b1;
    operation <= op;
    value <= val;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  task hold_off(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function logic [15:0] pick_value();
    logic [15:0] val;
    int unsigned pow;
    case ($urandom_range(0, 5))
      0, 1: val = 16'($urandom);
      2: val = 16'($urandom_range(0, 99));
      3: val = 16'(17'h10000 - $urandom_range(1, 120));
      4: begin
        pow = 1;
        repeat ($urandom_range(0, 4)) pow = pow * 10;
        val = 16'(pow + $urandom_range(0, 2) - 1);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: val = 16'h0000;
          1: val = 16'h7FFF;
          2: val = 16'h8000;
          3: val = 16'h8001;
          default: val = 16'hFFFF;
        endcase
      end
    endcase
    return val;
  endfunction

  logic        dir_op  [DirectedCount];
  logic [15:0] dir_val [DirectedCount];

  initial begin
    dir_op = '{OpUnsigned, OpSigned, OpUnsigned, OpSigned, OpSigned, OpSigned, OpUnsigned,
               OpUnsigned, OpSigned, OpUnsigned, OpUnsigned, OpUnsigned, OpUnsigned,
               OpUnsigned, OpUnsigned, OpSigned, OpSigned, OpUnsigned, OpSigned,
               OpUnsigned, OpSigned};
    dir_val = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000,
                16'd1, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100,
                16'd9999, 16'd10000, 16'h8001, 16'hFFF6, 16'd10009, 16'hD8F0,
                16'd12345, 16'hFFF7};
    rst = 1'b1;
    start = 1'b0;
    operation = OpUnsigned;
    value = 16'd0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed items go back to back, so the next start follows each accept at once.
    for (int i = 0; i < DirectedCount; i++) send_item(dir_op[i], dir_val[i]);

    hold_off(1);
    wait_drained();

    for (int i = 0; i < RandomCount; i++) begin
      if (i == RandomCount / 2) begin
        hold_off(1);
        wait_drained();
      end
      if (i < RandomCount - CalmTail && $urandom_range(0, 2) == 0)
        hold_off($urandom_range(1, 19));
      send_item(logic'($urandom_range(0, 1)), pick_value());
    end

    hold_off(1);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d characters never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("binary_to_decimal_ascii_unit verification clean");
    end else begin
      $display("binary_to_decimal_ascii_unit verification failed");
    end
    $finish;
  end

endmodule
